### rtl/core/hd_pkg.sv
`default_nettype none
package hd_pkg;

  localparam int unsigned CORDIC_STEPS = 30;
  localparam int unsigned SQRT_STEPS   = 31;

  // binary angle conversion: floor(mag / 45) by reciprocal, remainder by table
  localparam logic [25:0] RECIP45  = 26'd47721859;
  localparam int unsigned DEG_FULL = 360;
  localparam int unsigned DEG_HALF = 720;

  localparam logic signed [33:0] GAIN_Q30     = 34'sd652032874;
  localparam logic signed [33:0] QUARTER_TURN = 34'sd1073741824;
  localparam logic signed [33:0] HALF_TURN    = 34'sd2147483648;
  localparam logic [30:0]        Q30_ONE      = 31'h4000_0000;
  localparam logic [30:0]        PI_Q29       = 31'd1686629713;
  localparam logic [49:0]        ROUND_HALF   = 50'h20_0000;
  localparam logic [25:0]        OUT_MAX      = 26'h3FF_FFFF;
  localparam logic [15:0]        RADIUS_RESET = 16'd3950;

  typedef enum logic [0:0] {
    REG_SPHERE_RADIUS = 1'b0
  } hd_reg_e;

  typedef logic [29:0] hd_atan_t [CORDIC_STEPS];

  localparam hd_atan_t ATAN_TURNS = '{
    30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
    30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
    30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722,
    30'd20861, 30'd10430, 30'd5215, 30'd2608, 30'd1304,
    30'd652, 30'd326, 30'd163, 30'd81, 30'd41,
    30'd20, 30'd10, 30'd5, 30'd3, 30'd1
  };

  typedef logic [12:0] hd_tab_t [64];

  function automatic hd_tab_t gen_tab_full();
    hd_tab_t t;
    for (int b = 0; b < 64; b++) begin
      t[b] = (b < 45) ? 13'((b * 65536 + DEG_FULL / 2) / DEG_FULL) : 13'd0;
    end
    return t;
  endfunction

  function automatic hd_tab_t gen_tab_half();
    hd_tab_t t;
    for (int b = 0; b < 64; b++) begin
      t[b] = (b < 45) ? 13'((b * 65536 + DEG_HALF / 2) / DEG_HALF) : 13'd0;
    end
    return t;
  endfunction

  localparam hd_tab_t TAB_FULL = gen_tab_full();
  localparam hd_tab_t TAB_HALF = gen_tab_half();

  // sideband that rides along every pipeline stage
  typedef struct packed {
    logic valid;
    logic same;
  } hd_tag_t;

endpackage
`default_nettype wire

### rtl/core/hd_bam.sv
`default_nettype none
module hd_bam
  import hd_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               en_i,
  input  wire logic               half_i,
  input  wire hd_tag_t            tag_i,
  input  wire logic signed [25:0] v_i,
  output hd_tag_t                 tag_o,
  output logic [31:0]             bam_o
);

  hd_tag_t     tag1_q, tag2_q, tag3_q;
  logic        neg1_q, neg2_q;
  logic [24:0] mag1_q, mag2_q;
  logic [19:0] quo2_q;
  logic [31:0] bam3_q;

  logic [25:0] absv;
  logic [50:0] prod;
  logic [24:0] rem;
  logic [5:0]  idx;
  logic [32:0] q;

  assign absv = v_i[25] ? 26'(-v_i) : v_i;
  assign prod = mag1_q * RECIP45;
  assign rem  = mag2_q - 25'(25'(quo2_q) * 25'd45);
  assign idx  = rem[5:0];

  always_comb begin
    if (half_i) begin
      q = {1'b0, quo2_q, 12'b0} + 33'(TAB_HALF[idx]);
    end else begin
      q = {quo2_q, 13'b0} + 33'(TAB_FULL[idx]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag1_q <= '0;
      tag2_q <= '0;
      tag3_q <= '0;
    end else if (en_i) begin
      tag1_q <= tag_i;
      tag2_q <= tag1_q;
      tag3_q <= tag2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg1_q <= v_i[25];
      mag1_q <= absv[24:0];
      neg2_q <= neg1_q;
      mag2_q <= mag1_q;
      quo2_q <= prod[50:31];
      bam3_q <= neg2_q ? -q[31:0] : q[31:0];
    end
  end

  assign tag_o = tag3_q;
  assign bam_o = bam3_q;

endmodule
`default_nettype wire

### rtl/core/hd_sincos.sv
`default_nettype none
module hd_sincos
  import hd_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               en_i,
  input  wire hd_tag_t            tag_i,
  input  wire logic [31:0]        ang_i,
  output hd_tag_t                 tag_o,
  output logic signed [31:0]      cos_o,
  output logic signed [31:0]      sin_o
);

  hd_tag_t            tag_q [CORDIC_STEPS+1];
  logic               flip_q [CORDIC_STEPS+1];
  logic signed [33:0] x_q [CORDIC_STEPS+1];
  logic signed [33:0] y_q [CORDIC_STEPS+1];
  logic signed [33:0] z_q [CORDIC_STEPS+1];
  hd_tag_t            tag_out_q;
  logic signed [31:0] cos_q, sin_q;

  logic signed [33:0] z_in, z_fold;
  logic               flip;

  // fold into a quarter turn each side, undo with a final negation
  assign z_in = 34'($signed(ang_i));
  always_comb begin
    z_fold = z_in;
    flip   = 1'b0;
    if (z_in > QUARTER_TURN) begin
      z_fold = z_in - HALF_TURN;
      flip   = 1'b1;
    end else if (z_in < -QUARTER_TURN) begin
      z_fold = z_in + HALF_TURN;
      flip   = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q[0]  <= '0;
      tag_out_q <= '0;
    end else if (en_i) begin
      tag_q[0]  <= tag_i;
      tag_out_q <= tag_q[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]    <= GAIN_Q30;
      y_q[0]    <= '0;
      z_q[0]    <= z_fold;
      flip_q[0] <= flip;
      cos_q     <= flip_q[CORDIC_STEPS] ? 32'(-x_q[CORDIC_STEPS]) : x_q[CORDIC_STEPS][31:0];
      sin_q     <= flip_q[CORDIC_STEPS] ? 32'(-y_q[CORDIC_STEPS]) : y_q[CORDIC_STEPS][31:0];
    end
  end

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_step
    logic signed [33:0] dx, dy, da;
    assign dx = x_q[g] >>> g;
    assign dy = y_q[g] >>> g;
    assign da = $signed({4'b0, ATAN_TURNS[g]});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        tag_q[g+1] <= '0;
      end else if (en_i) begin
        tag_q[g+1] <= tag_q[g];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        flip_q[g+1] <= flip_q[g];
        if (!z_q[g][33]) begin
          x_q[g+1] <= x_q[g] - dy;
          y_q[g+1] <= y_q[g] + dx;
          z_q[g+1] <= z_q[g] - da;
        end else begin
          x_q[g+1] <= x_q[g] + dy;
          y_q[g+1] <= y_q[g] - dx;
          z_q[g+1] <= z_q[g] + da;
        end
      end
    end
  end

  assign tag_o = tag_out_q;
  assign cos_o = cos_q;
  assign sin_o = sin_q;

endmodule
`default_nettype wire

### rtl/core/hd_isqrt.sv
`default_nettype none
module hd_isqrt
  import hd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        en_i,
  input  wire hd_tag_t     tag_i,
  input  wire logic [60:0] v_i,
  output hd_tag_t          tag_o,
  output logic [30:0]      root_o
);

  hd_tag_t     tag_q [SQRT_STEPS+1];
  logic [61:0] v_q [SQRT_STEPS+1];
  logic [61:0] r_q [SQRT_STEPS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q[0] <= '0;
    end else if (en_i) begin
      tag_q[0] <= tag_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      v_q[0] <= 62'(v_i);
      r_q[0] <= '0;
    end
  end

  // one result bit per stage, bit weight 4^(30-g)
  for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_step
    logic [61:0] bitw, trial;
    assign bitw  = 62'(1) << (60 - 2 * g);
    assign trial = r_q[g] + bitw;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        tag_q[g+1] <= '0;
      end else if (en_i) begin
        tag_q[g+1] <= tag_q[g];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (v_q[g] >= trial) begin
          v_q[g+1] <= v_q[g] - trial;
          r_q[g+1] <= (r_q[g] >> 1) + bitw;
        end else begin
          v_q[g+1] <= v_q[g];
          r_q[g+1] <= r_q[g] >> 1;
        end
      end
    end
  end

  assign tag_o  = tag_q[SQRT_STEPS];
  assign root_o = r_q[SQRT_STEPS][30:0];

endmodule
`default_nettype wire

### rtl/core/hd_atan.sv
`default_nettype none
module hd_atan
  import hd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        en_i,
  input  wire hd_tag_t     tag_i,
  input  wire logic [30:0] y_i,
  input  wire logic [30:0] x_i,
  output hd_tag_t          tag_o,
  output logic [30:0]      theta_o
);

  hd_tag_t            tag_q [CORDIC_STEPS+1];
  logic               zero_q [CORDIC_STEPS+1];
  logic signed [33:0] x_q [CORDIC_STEPS+1];
  logic signed [33:0] y_q [CORDIC_STEPS+1];
  logic signed [33:0] z_q [CORDIC_STEPS+1];
  hd_tag_t            tag_out_q;
  logic [30:0]        theta_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q[0]  <= '0;
      tag_out_q <= '0;
    end else if (en_i) begin
      tag_q[0]  <= tag_i;
      tag_out_q <= tag_q[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]    <= $signed({3'b0, x_i});
      y_q[0]    <= $signed({3'b0, y_i});
      z_q[0]    <= '0;
      zero_q[0] <= (y_i == '0);
      // zero height, or a negative angle, gives zero
      if (zero_q[CORDIC_STEPS] || z_q[CORDIC_STEPS][33]) begin
        theta_q <= '0;
      end else begin
        theta_q <= z_q[CORDIC_STEPS][30:0];
      end
    end
  end

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_step
    logic signed [33:0] dx, dy, da;
    assign dx = y_q[g] >>> g;
    assign dy = x_q[g] >>> g;
    assign da = $signed({4'b0, ATAN_TURNS[g]});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        tag_q[g+1] <= '0;
      end else if (en_i) begin
        tag_q[g+1] <= tag_q[g];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        zero_q[g+1] <= zero_q[g];
        if (!y_q[g][33]) begin
          x_q[g+1] <= x_q[g] + dx;
          y_q[g+1] <= y_q[g] - dy;
          z_q[g+1] <= z_q[g] + da;
        end else begin
          x_q[g+1] <= x_q[g] - dx;
          y_q[g+1] <= y_q[g] + dy;
          z_q[g+1] <= z_q[g] - da;
        end
      end
    end
  end

  assign tag_o   = tag_out_q;
  assign theta_o = theta_q;

endmodule
`default_nettype wire

### rtl/core/haversine_distance.sv
// channel   | handshake                 | payload
// ----------+---------------------------+---------------------------------------
// in        | in_valid_i / in_stall_o   | first_lat_i first_lon_i second_lat_i
//           |                           | second_lon_i (Q16 degrees, signed)
// out       | out_valid_o / out_stall_i | arc_distance_o (Q8, unsigned)
// cfg (apb) | psel penable pwrite pready| paddr pwdata prdata
//
// one beat accepted per cycle while no held result stalls the pipeline
// the pipeline is mostly the 30-step rotation cordic, the 31-step square root and
// the 30-step vectoring cordic, each one step per register stage
// reset clears the valid bits of every stage and loads the radius with 3950
// a stalled result freezes the whole pipeline; input stall follows at once
`default_nettype none
module haversine_distance
  import hd_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // input beats
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic signed [24:0] first_lat_i,
  input  wire logic signed [24:0] first_lon_i,
  input  wire logic signed [24:0] second_lat_i,
  input  wire logic signed [24:0] second_lon_i,
  // result beats
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [25:0]             arc_distance_o,
  // config port
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  // ---------------------------------------------------------------- config
  logic [15:0] radius_q;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_SPHERE_RADIUS) ? {16'b0, radius_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RADIUS_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_SPHERE_RADIUS) begin
      radius_q <= pwdata[15:0];
    end
  end

  // ------------------------------------------------------- pipeline enable
  // every stage moves together unless the result register is held
  logic en;
  hd_tag_t out_tag_q;

  assign en         = !(out_tag_q.valid && out_stall_i);
  assign in_stall_o = !en;

  // ------------------------------------------------ stage 0: input register
  hd_tag_t            tag0_q, tag0_d;
  logic signed [25:0] lat1_q, lat2_q, dlat_q, dlon_q;

  assign tag0_d.valid = in_valid_i;
  assign tag0_d.same  = (first_lat_i == second_lat_i) && (first_lon_i == second_lon_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag0_q <= '0;
    end else if (en) begin
      tag0_q <= tag0_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      lat1_q <= 26'(first_lat_i);
      lat2_q <= 26'(second_lat_i);
      dlat_q <= 26'(second_lat_i) - 26'(first_lat_i);
      dlon_q <= 26'(second_lon_i) - 26'(first_lon_i);
    end
  end

  // ----------------------------------------- degrees to binary angles (3)
  hd_tag_t     tag_bam;
  logic [31:0] ang_lat1, ang_lat2, ang_dlat, ang_dlon;

  hd_bam u_bam_lat1 (
    .clk_i, .rst_ni, .en_i(en), .half_i(1'b0), .tag_i(tag0_q), .v_i(lat1_q),
    .tag_o(tag_bam), .bam_o(ang_lat1)
  );
  hd_bam u_bam_lat2 (
    .clk_i, .rst_ni, .en_i(en), .half_i(1'b0), .tag_i(tag0_q), .v_i(lat2_q),
    .tag_o(), .bam_o(ang_lat2)
  );
  // half angles for the haversine terms
  hd_bam u_bam_dlat (
    .clk_i, .rst_ni, .en_i(en), .half_i(1'b1), .tag_i(tag0_q), .v_i(dlat_q),
    .tag_o(), .bam_o(ang_dlat)
  );
  hd_bam u_bam_dlon (
    .clk_i, .rst_ni, .en_i(en), .half_i(1'b1), .tag_i(tag0_q), .v_i(dlon_q),
    .tag_o(), .bam_o(ang_dlon)
  );

  // --------------------------------------------- sine and cosine (32 each)
  hd_tag_t            tag_sc;
  logic signed [31:0] cos_lat1, cos_lat2, sin_dlat, sin_dlon;

  hd_sincos u_sc_lat1 (
    .clk_i, .rst_ni, .en_i(en), .tag_i(tag_bam), .ang_i(ang_lat1),
    .tag_o(tag_sc), .cos_o(cos_lat1), .sin_o()
  );
  hd_sincos u_sc_lat2 (
    .clk_i, .rst_ni, .en_i(en), .tag_i(tag_bam), .ang_i(ang_lat2),
    .tag_o(), .cos_o(cos_lat2), .sin_o()
  );
  hd_sincos u_sc_dlat (
    .clk_i, .rst_ni, .en_i(en), .tag_i(tag_bam), .ang_i(ang_dlat),
    .tag_o(), .cos_o(), .sin_o(sin_dlat)
  );
  hd_sincos u_sc_dlon (
    .clk_i, .rst_ni, .en_i(en), .tag_i(tag_bam), .ang_i(ang_dlon),
    .tag_o(), .cos_o(), .sin_o(sin_dlon)
  );

  // ---------------------------------------------- haversine term a (3 stages)
  hd_tag_t            tag_p1_q, tag_p2_q, tag_p3_q;
  logic signed [31:0] p1_shl_q, p1_c12_q, p1_sho_q;
  logic signed [31:0] p2_shl_q, p2_m_q;
  logic [30:0]        a_q;

  logic signed [63:0] shl_sq, c12, sho_sq, mprod;
  logic signed [32:0] asum;
  logic [30:0]        a_d;

  assign shl_sq = sin_dlat * sin_dlat;
  assign c12    = cos_lat1 * cos_lat2;
  assign sho_sq = sin_dlon * sin_dlon;
  assign mprod  = p1_c12_q * p1_sho_q;
  assign asum   = 33'(p2_shl_q) + 33'(p2_m_q);

  // clamp a to [0, 1] in Q30
  always_comb begin
    if (asum[32]) begin
      a_d = '0;
    end else if (asum > $signed({2'b0, Q30_ONE})) begin
      a_d = Q30_ONE;
    end else begin
      a_d = asum[30:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_p1_q <= '0;
      tag_p2_q <= '0;
      tag_p3_q <= '0;
    end else if (en) begin
      tag_p1_q <= tag_sc;
      tag_p2_q <= tag_p1_q;
      tag_p3_q <= tag_p2_q;
    end
  end

  // products are floor-shifted by 30, the arithmetic shift does the floor
  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_shl_q <= shl_sq[61:30];
      p1_c12_q <= c12[61:30];
      p1_sho_q <= sho_sq[61:30];
      p2_shl_q <= p1_shl_q;
      p2_m_q   <= mprod[61:30];
      a_q      <= a_d;
    end
  end

  // --------------------------------------------------- square roots (32)
  hd_tag_t     tag_sq;
  logic [30:0] root_a, root_b;
  logic [30:0] one_minus_a;

  assign one_minus_a = Q30_ONE - a_q;

  hd_isqrt u_sqrt_a (
    .clk_i, .rst_ni, .en_i(en), .tag_i(tag_p3_q), .v_i({a_q, 30'b0}),
    .tag_o(tag_sq), .root_o(root_a)
  );
  hd_isqrt u_sqrt_b (
    .clk_i, .rst_ni, .en_i(en), .tag_i(tag_p3_q), .v_i({one_minus_a, 30'b0}),
    .tag_o(), .root_o(root_b)
  );

  // --------------------------------------------------------- atan2 (32)
  hd_tag_t     tag_at;
  logic [30:0] theta;

  hd_atan u_atan (
    .clk_i, .rst_ni, .en_i(en), .tag_i(tag_sq), .y_i(root_a), .x_i(root_b),
    .tag_o(tag_at), .theta_o(theta)
  );

  // ------------------------------------ angle to distance and output (3)
  hd_tag_t     tag_t_q, tag_d_q;
  logic [32:0] t_q;
  logic [48:0] dist_q;
  logic [25:0] out_q;

  logic [61:0] tprod;
  logic [49:0] dsum;
  logic [27:0] dist_r;
  logic [25:0] out_d;

  assign tprod  = theta * PI_Q29;
  assign dsum   = 50'(dist_q) + ROUND_HALF;
  assign dist_r = dsum[49:22];

  // identical points short-circuit to zero, large distances saturate
  always_comb begin
    if (tag_d_q.same) begin
      out_d = '0;
    end else if (dist_r > 28'(OUT_MAX)) begin
      out_d = OUT_MAX;
    end else begin
      out_d = dist_r[25:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_t_q   <= '0;
      tag_d_q   <= '0;
      out_tag_q <= '0;
    end else if (en) begin
      tag_t_q   <= tag_at;
      tag_d_q   <= tag_t_q;
      out_tag_q <= tag_d_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      t_q    <= tprod[61:29];
      dist_q <= radius_q * t_q;
      out_q  <= out_d;
    end
  end

  assign out_valid_o    = out_tag_q.valid;
  assign arc_distance_o = out_q;

endmodule
`default_nettype wire

### rtl/core/hd_checker.sv
`default_nettype none
module hd_checker
  import hd_pkg::*;
(
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_stall_o,
  input wire logic signed [24:0] first_lat_i,
  input wire logic signed [24:0] first_lon_i,
  input wire logic signed [24:0] second_lat_i,
  input wire logic signed [24:0] second_lon_i,
  input wire logic               out_valid_o,
  input wire logic               out_stall_i,
  input wire logic [25:0]        arc_distance_o,
  input wire logic               psel,
  input wire logic               penable,
  input wire logic               pwrite,
  input wire logic [2:0]         paddr,
  input wire logic [31:0]        pwdata,
  input wire logic [31:0]        prdata,
  input wire logic               pready
);

  // a held result beat stays valid
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  // a held result beat keeps its value
  a_out_stable : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(arc_distance_o))
    else $error("result changed while stalled");

  // the input side is only held back by a held result
  a_in_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a held result");

  // a radius write reads back in the next cycle
  a_radius_rb : assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && pready && paddr[2] == REG_SPHERE_RADIUS
    |=> (psel && !pwrite && paddr[2] == REG_SPHERE_RADIUS)
        -> prdata == {16'b0, $past(pwdata[15:0])})
    else $error("radius readback mismatch");

endmodule

bind haversine_distance hd_checker u_hd_checker (.*);
`default_nettype wire

### bench/tb_top.sv
module tb_top
  import hd_pkg::*;
();

  // range of one coordinate field: +-180 degrees in q16
  localparam int DEG_LIMIT = 11796480;
  localparam int DEG_90    = 5898240;
  // settle time after the last pending distance, used with a margin when draining
  localparam int PIPE_DEPTH = 105;
  // watchdog: cycles in a row with no beat on either channel
  localparam int STALL_LIMIT = 4000;
  // long receiver hold-off that fills the pipeline
  localparam int HOLD_CYCLES = 400;
  localparam int RANDOM_PER_PHASE = 235;

  localparam logic [2:0] ADDR_RADIUS = 3'(4 * int'(REG_SPHERE_RADIUS));
  // first address past the register list, writes there are dropped
  localparam logic [2:0] ADDR_UNUSED = 3'd4;

  typedef logic signed [24:0] coord_t;

  // distance predictor and queue of pending distances
  class distance_board;
    logic [15:0] radius;
    logic [25:0] pending_dist[$];
    int unsigned mismatches;
    int unsigned pairs_in;
    int unsigned dists_out;
    int unsigned same_pairs;

    function new();
      radius = RADIUS_RESET;
      mismatches = 0;
      pairs_in = 0;
      dists_out = 0;
      same_pairs = 0;
    endfunction

    task report(string what, longint got, longint want);
      mismatches++;
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    endtask

    // degrees q16 to binary angle, halves away from zero
    function logic [31:0] to_turn(longint deg, longint unsigned div);
      longint unsigned mag, q;
      mag = (deg < 0) ? longint'(-deg) : longint'(deg);
      q = (mag * 65536 + div / 2) / div;
      if (deg < 0) q = -q;
      return q[31:0];
    endfunction

    // rotation-mode cordic, folded into [-1/4, 1/4] turn
    function void rotate(logic [31:0] ang, output longint cos_q, output longint sin_q);
      longint z, x, y, dx, dy;
      bit flip;
      z = longint'($signed(ang));
      x = GAIN_Q30;
      y = 0;
      flip = 0;
      if (z > QUARTER_TURN) begin
        z -= HALF_TURN;
        flip = 1;
      end else if (z < -QUARTER_TURN) begin
        z += HALF_TURN;
        flip = 1;
      end
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx; y += dy; z -= longint'(ATAN_TURNS[i]);
        end else begin
          x += dx; y -= dy; z += longint'(ATAN_TURNS[i]);
        end
      end
      cos_q = flip ? -x : x;
      sin_q = flip ? -y : y;
    endfunction

    function longint floor_root(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return longint'(r);
    endfunction

    // vectoring-mode cordic, angle of (x, y) in binary turns
    function longint vector_angle(longint y, longint x);
      longint z, dx, dy;
      z = 0;
      if (y == 0) return 0;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y >= 0) begin
          x += dx; y -= dy; z += longint'(ATAN_TURNS[i]);
        end else begin
          x -= dx; y += dy; z -= longint'(ATAN_TURNS[i]);
        end
      end
      return (z < 0) ? 0 : z;
    endfunction

    function logic [25:0] great_circle(coord_t lat1, coord_t lon1, coord_t lat2, coord_t lon2);
      longint c1, s1, c2, s2, chl, shl, cho, sho, hav, sy, sx, theta;
      longint unsigned arc, span;
      if (lat1 == lat2 && lon1 == lon2) return '0;
      rotate(to_turn(longint'(lat1), DEG_FULL), c1, s1);
      rotate(to_turn(longint'(lat2), DEG_FULL), c2, s2);
      rotate(to_turn(longint'(lat2) - longint'(lat1), DEG_HALF), chl, shl);
      rotate(to_turn(longint'(lon2) - longint'(lon1), DEG_HALF), cho, sho);
      // a = sin^2(dlat/2) + cos lat1 cos lat2 sin^2(dlon/2), q30
      hav = ((shl * shl) >>> 30) + ((((c1 * c2) >>> 30) * ((sho * sho) >>> 30)) >>> 30);
      if (hav < 0) hav = 0;
      if (hav > longint'(Q30_ONE)) hav = Q30_ONE;
      sy = floor_root(longint'(hav) << 30);
      sx = floor_root((longint'(Q30_ONE) - hav) << 30);
      theta = vector_angle(sy, sx);
      arc = (longint'(theta) * longint'(PI_Q29)) >> 29;
      span = (longint'(radius) * arc + longint'(ROUND_HALF)) >> 22;
      if (span > longint'(OUT_MAX)) span = OUT_MAX;
      return span[25:0];
    endfunction

    function void note_pair(coord_t lat1, coord_t lon1, coord_t lat2, coord_t lon2);
      pairs_in++;
      if (lat1 == lat2 && lon1 == lon2) same_pairs++;
      pending_dist.push_back(great_circle(lat1, lon1, lat2, lon2));
    endfunction

    task check_distance(logic [25:0] got);
      logic [25:0] want;
      dists_out++;
      if (pending_dist.size() == 0) begin
        report("unexpected distance", got, -1);
      end else begin
        want = pending_dist.pop_front();
        if (got !== want) report("arc_distance", got, want);
      end
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  coord_t      first_lat_i, first_lon_i, second_lat_i, second_lon_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [25:0] arc_distance_o;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;

  distance_board board;
  bit hold_req;     // sender asks the receiver for a long hold-off
  bit calm;         // no idling on either side
  int idle_cycles;

  haversine_distance dut (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_o,
    .first_lat_i, .first_lon_i, .second_lat_i, .second_lon_i,
    .out_valid_o, .out_stall_i, .arc_distance_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  initial begin
    clk_i = 0;
    forever #1 clk_i = ~clk_i;
  end

  // mostly no gap, often a short one, a few long ones; none at all while calm
  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 45);
  endfunction

  // accepted beats on both channels, sampled before the edge updates land
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        board.note_pair(first_lat_i, first_lon_i, second_lat_i, second_lon_i);
      end
      if (out_valid_o && !out_stall_i) board.check_distance(arc_distance_o);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || psel) begin
        idle_cycles <= 0;
      end else if (board.pending_dist.size() == 0 && !in_valid_i) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles > STALL_LIMIT) begin
        $display("watchdog: no beat for %0d cycles", idle_cycles);
        $display("simulation failed");
        $finish;
      end
    end
  end

  // result side: random stall with an occasional long hold-off on request
  initial begin
    int len;
    out_stall_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 0;
        out_stall_i <= 1'b0;
        @(posedge clk_i);
      end else begin
        len = pick_gap();
        if (len > 0) begin
          out_stall_i <= 1'b1;
          repeat (len) @(posedge clk_i);
        end
        out_stall_i <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
    end
  end

  // one pair, held until the block takes it, then an optional gap
  task send_pair(coord_t lat1, coord_t lon1, coord_t lat2, coord_t lon2);
    int gap;
    in_valid_i   <= 1'b1;
    first_lat_i  <= lat1;
    first_lon_i  <= lon1;
    second_lat_i <= lat2;
    second_lon_i <= lon2;
    do @(posedge clk_i); while (in_stall_o);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task apb_write(logic [2:0] addr, logic [31:0] data);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task apb_check_radius();
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    paddr   <= ADDR_RADIUS;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata[15:0] !== board.radius) board.report("radius readback", prdata, board.radius);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // wait out every pending distance, then let the pipeline drain
  task drain();
    in_valid_i <= 1'b0;
    while (board.pending_dist.size() != 0) @(posedge clk_i);
    repeat (PIPE_DEPTH + 10) @(posedge clk_i);
  endtask

  task set_radius(logic [15:0] r);
    drain();
    apb_write(ADDR_RADIUS, {16'hA5A5, r});  // upper bits are not part of the register
    board.radius = r;
    apb_check_radius();
  endtask

  function coord_t any_coord();
    return coord_t'(int'($urandom_range(0, 2 * DEG_LIMIT)) - DEG_LIMIT);
  endfunction

  function coord_t near_coord(coord_t c);
    int v;
    v = int'(c) + int'($urandom_range(0, 2 * 600)) - 600;
    if (v > DEG_LIMIT) v = DEG_LIMIT;
    if (v < -DEG_LIMIT) v = -DEG_LIMIT;
    return coord_t'(v);
  endfunction

  // extremes, identical points, antipodes, latitudes past the poles
  task directed_pairs();
    send_pair(0, 0, 0, 0);
    send_pair(DEG_LIMIT, -DEG_LIMIT, DEG_LIMIT, -DEG_LIMIT);
    send_pair(-1, -1, -1, -1);
    send_pair(0, 0, 0, DEG_LIMIT);
    send_pair(0, -DEG_LIMIT, 0, DEG_LIMIT);
    send_pair(DEG_90, 0, -DEG_90, 0);
    send_pair(DEG_90, 12345, -DEG_90, -DEG_LIMIT);
    send_pair(DEG_LIMIT, 0, -DEG_LIMIT, 0);
    send_pair(-DEG_LIMIT, DEG_LIMIT, DEG_LIMIT, -DEG_LIMIT);
    send_pair(0, 0, 0, 1);
    send_pair(0, 0, 1, 0);
    send_pair(0, 0, -1, -1);
    send_pair(DEG_90, 0, DEG_90, DEG_LIMIT);
    send_pair(9830400, 0, -9830400, 0);        // latitudes of +-150
    send_pair(-9830400, 100, 3276800, -DEG_LIMIT);
    send_pair(0, 5898240, 0, -5898240);
    send_pair(2621440, -4718592, -2621440, 4718592);
    send_pair(DEG_LIMIT, DEG_LIMIT, -DEG_LIMIT, -DEG_LIMIT);
    send_pair(32768, 32768, -32768, -32768);
    send_pair(DEG_90 - 1, 0, -DEG_90 + 1, DEG_LIMIT);
  endtask

  // mostly independent pairs, some identical points, some close neighbors
  task random_pairs(int count);
    coord_t a, b, c, d;
    int kind;
    for (int n = 0; n < count; n++) begin
      kind = $urandom_range(0, 99);
      a = any_coord();
      b = any_coord();
      if (kind < 10) begin
        c = a; d = b;
      end else if (kind < 30) begin
        c = near_coord(a); d = near_coord(b);
      end else if (kind < 35) begin
        c = a; d = near_coord(b);
      end else begin
        c = any_coord(); d = any_coord();
      end
      // quiet stretches with back-to-back beats on both sides
      if (n % 80 == 40) calm = 1;
      if (n % 80 == 60) calm = 0;
      send_pair(a, b, c, d);
    end
    calm = 0;
  endtask

  initial begin
    logic [15:0] radii[6];
    board = new();
    hold_req = 0;
    calm = 0;
    idle_cycles = 0;
    rst_ni = 1'b0;
    in_valid_i <= 1'b0;
    first_lat_i <= '0;
    first_lon_i <= '0;
    second_lat_i <= '0;
    second_lon_i <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    // reset radius first, then largest, smallest, zero and a couple of others
    radii = '{RADIUS_RESET, 16'hFFFF, 16'd1, 16'd0, 16'($urandom_range(2, 65534)), 16'd6371};
    apb_check_radius();
    foreach (radii[p]) begin
      if (p > 0) set_radius(radii[p]);
      // the write past the register list must leave the radius alone
      if (p == 2) begin
        apb_write(ADDR_UNUSED, 32'h0000_1234);
        apb_check_radius();
      end
      if (p < 2) directed_pairs();
      // fill the pipeline behind a long result hold-off
      if (p == 1) hold_req = 1;
      random_pairs(RANDOM_PER_PHASE);
    end
    drain();
    if (board.pending_dist.size() != 0) begin
      board.report("distances never delivered", 0, board.pending_dist.size());
    end

    $display("covered %0d point pairs (%0d identical) and %0d distances over %0d radius settings",
             board.pairs_in, board.same_pairs, board.dists_out, $size(radii));
    $display("radius extremes 65535, 1 and 0 included; %0d mismatches", board.mismatches);
    if (board.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
